>>> hdl/zero_tile_flag_compactor_core_assert.svh
// Assertion macros used by the compactor's drain module.
// ZTFC_ASSERT_NOW : consequent must hold in the same cycle as the antecedent.
// ZTFC_ASSERT_NEXT: consequent must hold one cycle after the antecedent.
`ifndef ZERO_TILE_FLAG_COMPACTOR_CORE_ASSERT_SVH
`define ZERO_TILE_FLAG_COMPACTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ZTFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ZTFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ZTFC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define ZTFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/ztfc_pkg.sv
package ztfc_pkg;

   // tile geometry
   localparam int TILE_ROWS  = 16;
   localparam int TILE_COLS  = 4;
   localparam int TILE_WORDS = TILE_ROWS * TILE_COLS;
   localparam int POS_W      = (TILE_WORDS > 1) ? $clog2(TILE_WORDS) : 1;
   localparam int ADDR_W     = POS_W + 1;          // bank bit on top of position
   localparam int MEM_DEPTH  = 2 ** ADDR_W;

   localparam int WORD_W     = 32;
   localparam int TILES_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int USER_W     = 2;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(TILE_WORDS - 1);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMPACT_MODE    = 2'd0,
      CSR_FLAG_WORD       = 2'd1,
      CSR_TILES_IN_MATRIX = 2'd2
   } csr_index_type;

   // tile store ports
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // what the drain needs to know about a finished tile
   typedef struct packed {
      logic              bank;
      logic              zero_tile;
      logic              compact;
      logic [WORD_W-1:0] flag;
      logic              matrix_end;
   } tile_meta_type;

endpackage

>>> hdl/ztfc_tile_store.sv
module ztfc_tile_store (
   input  logic                          clock,
   input  ztfc_pkg::ram_wr_type          wr,
   input  ztfc_pkg::ram_rd_type          rd,
   output logic [ztfc_pkg::WORD_W-1:0]   rdata
);

   // two tile banks, one write port, one registered read port
   logic [ztfc_pkg::WORD_W-1:0] tile_mem_ff [ztfc_pkg::MEM_DEPTH];
   logic [ztfc_pkg::WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         tile_mem_ff[wr.addr] <= wr.data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= tile_mem_ff[rd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/ztfc_drain.sv
`include "zero_tile_flag_compactor_core_assert.svh"

module ztfc_drain (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  ztfc_pkg::tile_meta_type           meta,
   output logic                              busy,
   output ztfc_pkg::ram_rd_type              rd,
   input  logic [ztfc_pkg::WORD_W-1:0]       rdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ztfc_pkg::WORD_W-1:0]       rsp_tdata,  // [31:0] out_word
   output logic [ztfc_pkg::USER_W-1:0]       rsp_tuser,  // [0] is_marker, [1] matrix_end
   output logic                              rsp_tlast   // tile_end
);

   ztfc_pkg::tile_meta_type     meta_ff, meta_in;
   logic                        active_ff, active_in;
   logic [ztfc_pkg::POS_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                        pend_ff, pend_in;
   logic [ztfc_pkg::POS_W-1:0]  pend_idx_ff, pend_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ztfc_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_marker_ff, rsp_marker_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_mend_ff, rsp_mend_in;

   logic out_free;
   logic load;
   logic issue;
   logic pend_sub;
   logic pend_last;

   // read pipeline: issue -> memory data register -> output word
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign load      = pend_ff && out_free;
   assign issue     = active_ff && (!pend_ff || load);
   assign pend_sub  = meta_ff.zero_tile && (pend_idx_ff == '0);
   assign pend_last = (pend_idx_ff == ztfc_pkg::LAST_POS);
   assign busy      = active_ff || pend_ff || rsp_valid_ff;

   assign rd.en   = issue;
   assign rd.addr = {meta_ff.bank, rd_idx_ff};

   always_comb begin
      meta_in       = meta_ff;
      active_in     = active_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_marker_in = rsp_marker_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_mend_in   = rsp_mend_ff;

      // read side
      if (issue) begin
         rd_idx_in   = rd_idx_ff + 1'b1;
         pend_idx_in = rd_idx_ff;
         if (rd_idx_ff == ztfc_pkg::LAST_POS) begin
            active_in = 1'b0;
         end
      end
      if (issue) begin
         pend_in = 1'b1;
      end else if (load) begin
         pend_in = 1'b0;
      end

      // output word
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_sub ? meta_ff.flag : rdata;
         rsp_marker_in = pend_sub;
         rsp_last_in   = pend_last;
         rsp_mend_in   = pend_last && meta_ff.matrix_end;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // new tile; only taken while idle
      if (start) begin
         meta_in = meta;
         if (meta.zero_tile && meta.compact) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = meta.flag;
            rsp_marker_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_mend_in   = meta.matrix_end;
         end else begin
            active_in = 1'b1;
            rd_idx_in = '0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      meta_ff       <= meta_in;
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_marker_ff <= rsp_marker_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_mend_ff   <= rsp_mend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_mend_ff, rsp_marker_ff};
   assign rsp_tlast  = rsp_last_ff;

   `ZTFC_ASSERT_NOW(a_start_when_idle, clock, reset, start, !busy, "tile handed over while drain busy")
   `ZTFC_ASSERT_NEXT(a_pend_holds, clock, reset, pend_ff && !load, pend_ff && $stable(pend_idx_ff), "pending read word lost under stall")
   `ZTFC_ASSERT_NEXT(a_compact_flag, clock, reset, start && meta.zero_tile && meta.compact, rsp_valid_ff && rsp_marker_ff && rsp_last_ff && !active_ff, "compact zero tile not sent as a single flag word")

endmodule

>>> hdl/zero_tile_flag_compactor_core.sv
// Zero-tile flag compactor. Weight words arrive on req_ one per cycle in tile order
// (TILE_ROWS x TILE_COLS words per tile, row-major) and are written into one bank of a
// double-banked tile store while the block tracks whether any word is nonzero. On a tile's
// last word the tile is handed to the drain: in compact mode an all-zero tile leaves as a
// single flag word, otherwise all TILE_WORDS words leave in order, the first replaced by the
// flag word for an all-zero tile (in-place mode). rsp_tlast marks each tile's last word,
// rsp_tuser[1] the last word of the matrix, rsp_tuser[0] a substituted flag word. Words
// within a tile are taken at one per cycle; the last word of a tile is held back until the
// previous tile has fully left the output register. A whole tile drains at one word per
// cycle through the store's single read port while the output is not stalled.
// Configuration writes on csr_ are registered; mode, flag and tile count are sampled on a
// tile's last word.
module zero_tile_flag_compactor_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ztfc_pkg::WORD_W-1:0]        req_tdata,   // [31:0] weight_word
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ztfc_pkg::WORD_W-1:0]        rsp_tdata,   // [31:0] out_word
   output logic [ztfc_pkg::USER_W-1:0]        rsp_tuser,   // [0] is_marker, [1] matrix_end
   output logic                               rsp_tlast,   // tile_end
   input  logic                               csr_we,
   input  logic [ztfc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ztfc_pkg::WORD_W-1:0]        csr_wdata
);

   logic                         compact_ff, compact_in;
   logic [ztfc_pkg::WORD_W-1:0]  flag_ff, flag_in;
   logic [ztfc_pkg::TILES_W-1:0] tiles_ff, tiles_in;
   logic [ztfc_pkg::POS_W-1:0]   wpos_ff, wpos_in;
   logic                         nonzero_ff, nonzero_in;
   logic [ztfc_pkg::TILES_W-1:0] tile_pos_ff, tile_pos_in;
   logic                         wbank_ff, wbank_in;

   logic                         accept;
   logic                         last_word;
   logic                         drain_busy;
   logic                         start;
   logic [ztfc_pkg::TILES_W-1:0] last_tile;
   logic                         mend;
   ztfc_pkg::tile_meta_type      meta;
   ztfc_pkg::ram_wr_type         wr;
   ztfc_pkg::ram_rd_type         rd;
   logic [ztfc_pkg::WORD_W-1:0]  rdata;

   // input side
   assign last_word  = (wpos_ff == ztfc_pkg::LAST_POS);
   assign req_tready = !(last_word && drain_busy);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && last_word;

   // a tile count of zero behaves as one
   assign last_tile = (tiles_ff == '0) ? '0 : tiles_ff - 1'b1;
   assign mend      = (tile_pos_ff >= last_tile);

   assign wr.en   = accept;
   assign wr.addr = {wbank_ff, wpos_ff};
   assign wr.data = req_tdata;

   assign meta.bank       = wbank_ff;
   assign meta.zero_tile  = !nonzero_ff && (req_tdata == '0);
   assign meta.compact    = compact_ff;
   assign meta.flag       = flag_ff;
   assign meta.matrix_end = mend;

   always_comb begin
      compact_in  = compact_ff;
      flag_in     = flag_ff;
      tiles_in    = tiles_ff;
      wpos_in     = wpos_ff;
      nonzero_in  = nonzero_ff;
      tile_pos_in = tile_pos_ff;
      wbank_in    = wbank_ff;

      // register writes
      if (csr_we) begin
         case (ztfc_pkg::csr_index_type'(csr_index))
            ztfc_pkg::CSR_COMPACT_MODE:    compact_in = csr_wdata[0];
            ztfc_pkg::CSR_FLAG_WORD:       flag_in    = csr_wdata;
            ztfc_pkg::CSR_TILES_IN_MATRIX: tiles_in   = csr_wdata[ztfc_pkg::TILES_W-1:0];
            default: ;
         endcase
      end

      // word and tile counting
      if (accept) begin
         if (last_word) begin
            wpos_in     = '0;
            nonzero_in  = 1'b0;
            wbank_in    = !wbank_ff;
            tile_pos_in = mend ? '0 : tile_pos_ff + 1'b1;
         end else begin
            wpos_in    = wpos_ff + 1'b1;
            nonzero_in = nonzero_ff || (req_tdata != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compact_ff  <= 1'b1;
         flag_ff     <= '0;
         tiles_ff    <= ztfc_pkg::TILES_W'(1);
         wpos_ff     <= '0;
         nonzero_ff  <= 1'b0;
         tile_pos_ff <= '0;
         wbank_ff    <= 1'b0;
      end else begin
         compact_ff  <= compact_in;
         flag_ff     <= flag_in;
         tiles_ff    <= tiles_in;
         wpos_ff     <= wpos_in;
         nonzero_ff  <= nonzero_in;
         tile_pos_ff <= tile_pos_in;
         wbank_ff    <= wbank_in;
      end
   end

   ztfc_tile_store u_store (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rdata (rdata)
   );

   ztfc_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .meta       (meta),
      .busy       (drain_busy),
      .rd         (rd),
      .rdata      (rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
